// ===== rtl/cbm_pkg.sv =====
package cbm_pkg;

   localparam int ROM_BANKS_DEFAULT = 128;
   localparam int RAM_BANKS_DEFAULT = 16;

   localparam int ADDR_W      = 16;
   localparam int DATA_W      = 8;
   localparam int TARGET_W    = 2;
   localparam int ROM_ADDR_W  = 21;
   localparam int RAM_ADDR_W  = 15;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_CART_KIND = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROM_BANKS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAM_BANKS = 2'd2;

   localparam logic [TARGET_W-1:0] TARGET_OPEN = 2'd0;
   localparam logic [TARGET_W-1:0] TARGET_ROM  = 2'd1;
   localparam logic [TARGET_W-1:0] TARGET_RAM  = 2'd2;

   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   localparam logic CART_PLAIN  = 1'b0;
   localparam logic CART_BANKED = 1'b1;

   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

   typedef struct packed {
      logic       cart_kind;
      logic [7:0] rom_bank_count;
      logic [4:0] ram_bank_count;
      logic [4:0] low_bank;
      logic [1:0] high_bank;
      logic       banking_mode;
      logic       ram_enabled;
   } cbm_state_type;

   typedef struct packed {
      logic       ram_enable_we;
      logic       ram_enable_val;
      logic       low_bank_we;
      logic [4:0] low_bank_val;
      logic       high_bank_we;
      logic [1:0] high_bank_val;
      logic       mode_we;
      logic       mode_val;
   } cbm_update_type;

   typedef struct packed {
      logic [TARGET_W-1:0]   target;
      logic [ROM_ADDR_W-1:0] rom_address;
      logic [RAM_ADDR_W-1:0] ram_address;
      logic                  ram_write;
      logic [DATA_W-1:0]     write_data;
   } cbm_result_type;

endpackage

// ===== rtl/cbm_if.sv =====
interface cbm_req_if;
   import cbm_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] data;

   modport source (output valid, output kind, output address, output data, input ready);
   modport sink   (input valid, input kind, input address, input data, output ready);
endinterface

interface cbm_rsp_if;
   import cbm_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [TARGET_W-1:0]   target;
   logic [ROM_ADDR_W-1:0] rom_address;
   logic [RAM_ADDR_W-1:0] ram_address;
   logic                  ram_write;
   logic [DATA_W-1:0]     write_data;

   modport source (output valid, output target, output rom_address, output ram_address,
                   output ram_write, output write_data, input ready);
   modport sink   (input valid, input target, input rom_address, input ram_address,
                   input ram_write, input write_data, output ready);
endinterface

// ===== rtl/cbm_regs.sv =====
module cbm_regs (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [cbm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cbm_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                               update_fire,
   input  cbm_pkg::cbm_update_type            update,
   output cbm_pkg::cbm_state_type             state
);
   import cbm_pkg::*;

   cbm_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_CART_KIND: state_in.cart_kind      = csr_data[0];
            CSR_ROM_BANKS: state_in.rom_bank_count = csr_data;
            CSR_RAM_BANKS: state_in.ram_bank_count = csr_data[4:0];
            default: ;
         endcase
      end
      if (update_fire) begin
         if (update.ram_enable_we) state_in.ram_enabled  = update.ram_enable_val;
         if (update.low_bank_we)   state_in.low_bank     = update.low_bank_val;
         if (update.high_bank_we)  state_in.high_bank    = update.high_bank_val;
         if (update.mode_we)       state_in.banking_mode = update.mode_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.cart_kind      <= CART_BANKED;
         state_ff.rom_bank_count <= 8'd2;
         state_ff.ram_bank_count <= 5'd0;
         state_ff.low_bank       <= 5'd1;
         state_ff.high_bank      <= 2'd0;
         state_ff.banking_mode   <= 1'b0;
         state_ff.ram_enabled    <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;
endmodule

// ===== rtl/cbm_translate.sv =====
module cbm_translate #(
   parameter int MAX_ROM_BANKS = cbm_pkg::ROM_BANKS_DEFAULT,
   parameter int MAX_RAM_BANKS = cbm_pkg::RAM_BANKS_DEFAULT
) (
   input  logic                          kind,
   input  logic [cbm_pkg::ADDR_W-1:0]    address,
   input  logic [cbm_pkg::DATA_W-1:0]    data,
   input  cbm_pkg::cbm_state_type        state,
   output cbm_pkg::cbm_update_type       update,
   output cbm_pkg::cbm_result_type       result
);
   import cbm_pkg::*;

   localparam logic [7:0] ROM_MAX = 8'(MAX_ROM_BANKS);
   localparam logic [4:0] RAM_MAX = 5'(MAX_RAM_BANKS);

   logic       banked;
   logic [7:0] rom_eff;
   logic [6:0] rom_mask;
   logic [4:0] ram_eff;
   logic [1:0] ram_bank_sel;
   logic [1:0] ram_bank;
   logic       ram_hit;
   logic       in_ram;
   logic [6:0] lo_bank;
   logic [6:0] hi_bank;
   logic [4:0] low_fixed;
   logic [6:0] rom_bank;

   always_comb begin
      banked = (state.cart_kind == CART_BANKED);
      in_ram = (address[15:13] == 3'b101);

      if (state.rom_bank_count < 8'd2)        rom_eff = 8'd2;
      else if (state.rom_bank_count > ROM_MAX) rom_eff = ROM_MAX;
      else                                     rom_eff = state.rom_bank_count;
      rom_mask = 7'(rom_eff - 8'd1);

      ram_eff = (state.ram_bank_count > RAM_MAX) ? RAM_MAX : state.ram_bank_count;

      // ram bank: high bank in mode 1 on a banked cartridge, else bank 0
      ram_bank_sel = (banked && kind == KIND_READ && state.banking_mode) ||
                     (banked && kind == KIND_WRITE && state.banking_mode) ?
                     state.high_bank : 2'd0;
      ram_bank = ram_bank_sel & 2'(ram_eff - 5'd1);
      ram_hit  = (ram_eff != 5'd0) && ({3'd0, ram_bank} < ram_eff);

      // zero bank promotion on the switchable window
      low_fixed = (state.low_bank == 5'd0) ? 5'd1 : state.low_bank;
      lo_bank = (banked && state.banking_mode) ? {state.high_bank, 5'd0} : 7'd0;
      hi_bank = banked ? {state.high_bank, low_fixed} : 7'd1;
      rom_bank = (address[15:14] == 2'b00) ? lo_bank : hi_bank;

      result = '0;
      update = '0;

      if (kind == KIND_READ) begin
         if (address[15] == 1'b0) begin
            result.target      = TARGET_ROM;
            result.rom_address = {rom_bank & rom_mask, address[13:0]};
         end else if (in_ram && banked && state.ram_enabled && ram_hit) begin
            result.target      = TARGET_RAM;
            result.ram_address = {ram_bank, address[12:0]};
         end
      end else if (banked) begin
         if (address[15] == 1'b0) begin
            unique case (address[14:13])
               2'b00: begin
                  update.ram_enable_we  = 1'b1;
                  update.ram_enable_val = (data[3:0] == RAM_ENABLE_KEY);
               end
               2'b01: begin
                  update.low_bank_we  = 1'b1;
                  update.low_bank_val = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
               end
               2'b10: begin
                  update.high_bank_we  = 1'b1;
                  update.high_bank_val = data[1:0];
               end
               2'b11: begin
                  update.mode_we  = 1'b1;
                  update.mode_val = data[0];
               end
            endcase
         end else if (in_ram && state.ram_enabled && ram_hit) begin
            result.ram_write   = 1'b1;
            result.ram_address = {ram_bank, address[12:0]};
            result.write_data  = data;
         end
      end else if (in_ram && ram_hit) begin
         result.ram_write   = 1'b1;
         result.ram_address = {ram_bank, address[12:0]};
         result.write_data  = data;
      end
   end
endmodule

// ===== rtl/cartridge_bank_mapper.sv =====
// Bank controller address translation for a banked game cartridge. Each request is one
// bus access (read or write, 16-bit address, data byte) and gives exactly one response:
// the read source (open bus, ROM or RAM) with the translated ROM or RAM byte address,
// or a RAM write strobe with its data. On a banked cartridge, writes below 0x8000 load
// the bank registers and affect every later request. A request is held in an input
// register, translated by masking and concatenation, and stored in an output register;
// throughput is one request per cycle while the response side keeps up. Configuration
// is written through the csr_ port only while no request is in flight; the user must
// ensure this, as the block does not enforce it. The ROM and RAM arrays sit outside it.
module cartridge_bank_mapper #(
   parameter int MAX_ROM_BANKS = cbm_pkg::ROM_BANKS_DEFAULT,
   parameter int MAX_RAM_BANKS = cbm_pkg::RAM_BANKS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   cbm_req_if.sink                         req_bus,
   cbm_rsp_if.source                       rsp_bus,
   input  logic                            csr_write,
   input  logic [cbm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cbm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import cbm_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_kind_ff;
   logic [ADDR_W-1:0] s1_address_ff;
   logic [DATA_W-1:0] s1_data_ff;
   logic              out_valid_ff, out_valid_in;
   cbm_result_type    out_result_ff;

   logic           advance;
   logic           req_fire;
   cbm_state_type  state;
   cbm_update_type update;
   cbm_result_type result;

   assign advance       = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign s1_valid_in   = req_fire || (s1_valid_ff && !advance);
   assign out_valid_in  = advance || (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff    <= req_bus.kind;
         s1_address_ff <= req_bus.address;
         s1_data_ff    <= req_bus.data;
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   cbm_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .update_fire (advance),
      .update      (update),
      .state       (state)
   );

   cbm_translate #(
      .MAX_ROM_BANKS (MAX_ROM_BANKS),
      .MAX_RAM_BANKS (MAX_RAM_BANKS)
   ) u_translate (
      .kind    (s1_kind_ff),
      .address (s1_address_ff),
      .data    (s1_data_ff),
      .state   (state),
      .update  (update),
      .result  (result)
   );

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.target      = out_result_ff.target;
   assign rsp_bus.rom_address = out_result_ff.rom_address;
   assign rsp_bus.ram_address = out_result_ff.ram_address;
   assign rsp_bus.ram_write   = out_result_ff.ram_write;
   assign rsp_bus.write_data  = out_result_ff.write_data;
endmodule
